### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression holds at every edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// types, codes and helpers shared by the text console glyph renderer
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int MAX_COLUMNS = 512;
  localparam int MAX_ROWS    = 256;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] COLOR_FIELD  = 8'hff;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CHAR  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_ROW    = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_TEXT_COLUMNS = 3'd0,
    REG_TEXT_ROWS    = 3'd1,
    REG_LINE_PITCH   = 3'd2,
    REG_FRAME_BASE   = 3'd3,
    REG_RED_SHIFT    = 3'd4,
    REG_GREEN_SHIFT  = 3'd5,
    REG_BLUE_SHIFT   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINE,
    ST_ADDR,
    ST_ROWS,
    ST_SCROLL,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [11:0] font_slot;
    logic [7:0]  font_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] row_address;
    logic [7:0]  row_pattern;
    logic [31:0] pixel_color;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_write_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic mult;
    logic seed;
    logic emit_row;
    logic emit_scroll;
    logic emit_clear;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic draw;
    logic scroll;
    logic scroll_pend;
    logic row_last;
    logic out_free;
  } dp_status_t;

  // white from three field positions, bits above 31 dropped
  function automatic logic [31:0] color_word(input logic [4:0] r_sh,
                                             input logic [4:0] g_sh,
                                             input logic [4:0] b_sh);
    logic [39:0] w;
    w = ({32'd0, COLOR_FIELD} << r_sh) | ({32'd0, COLOR_FIELD} << g_sh) |
        ({32'd0, COLOR_FIELD} << b_sh);
    return w[31:0];
  endfunction

endpackage

### rtl/tcgr_stream_if.sv
// ----------------------------------------------------------------------------
// tcgr_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface tcgr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/tcgr_ctrl.sv
// ----------------------------------------------------------------------------
// tcgr_ctrl
// sequencer: accepts items, steps address setup, scroll and clear commands and glyph row emission
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcgr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  logic [1:0]            cmd_op,
  output logic                  cmd_ready,
  input  tcgr_pkg::dp_status_t  status,
  output tcgr_pkg::ctrl_cmd_t   ctrl
);

  tcgr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcgr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    ctrl       = '0;
    unique case (state)
      tcgr_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctrl.take = 1'b1;
          unique case (cmd_op)
            tcgr_pkg::OP_CHAR: begin
              if (status.draw) begin
                state_next = tcgr_pkg::ST_LINE;
              end else if (status.scroll) begin
                state_next = tcgr_pkg::ST_SCROLL;
              end
            end
            tcgr_pkg::OP_CLEAR: begin
              state_next = tcgr_pkg::ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      tcgr_pkg::ST_LINE: begin
        ctrl.mult  = 1'b1;
        state_next = tcgr_pkg::ST_ADDR;
      end
      tcgr_pkg::ST_ADDR: begin
        ctrl.seed  = 1'b1;
        state_next = tcgr_pkg::ST_ROWS;
      end
      tcgr_pkg::ST_ROWS: begin
        if (status.out_free) begin
          ctrl.emit_row = 1'b1;
          if (status.row_last) begin
            state_next = status.scroll_pend ? tcgr_pkg::ST_SCROLL : tcgr_pkg::ST_IDLE;
          end
        end
      end
      tcgr_pkg::ST_SCROLL: begin
        if (status.out_free) begin
          ctrl.emit_scroll = 1'b1;
          state_next       = tcgr_pkg::ST_IDLE;
        end
      end
      tcgr_pkg::ST_CLEAR: begin
        if (status.out_free) begin
          ctrl.emit_clear = 1'b1;
          state_next      = tcgr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcgr_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_HOLDS(a_one_emit, clk, rst, $onehot0({ctrl.emit_row, ctrl.emit_scroll, ctrl.emit_clear}), "more than one result emitted in a cycle")
  `ASSERT_IMPLIES(a_ready_quiet, clk, rst, cmd_ready, !(ctrl.emit_row || ctrl.emit_scroll || ctrl.emit_clear || ctrl.mult || ctrl.seed), "input taken while an item is in flight")
  `ASSERT_NEXT(a_rows_end, clk, rst, ctrl.emit_row && status.row_last, state != tcgr_pkg::ST_ROWS, "glyph emission ran past its final row")

endmodule

### rtl/tcgr_datapath.sv
// ----------------------------------------------------------------------------
// tcgr_datapath
// registers, cursor, font store, row address generator and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcgr_datapath #(
  parameter int GLYPH_COUNT  = 256,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tcgr_pkg::in_item_t    cmd_item,
  input  logic                  cfg_valid,
  input  tcgr_pkg::cfg_write_t  cfg_item,
  input  tcgr_pkg::ctrl_cmd_t   ctrl,
  output tcgr_pkg::dp_status_t  status,
  output tcgr_pkg::out_item_t   res_item,
  output logic                  res_valid,
  input  logic                  res_ready
);

  localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int FA_W       = $clog2(FONT_DEPTH);
  localparam int RC_W       = $clog2(GLYPH_HEIGHT);
  localparam int LINE_W     = 8 + RC_W;
  localparam int PROD_W     = LINE_W + 16;

  // configuration
  logic [9:0]  text_columns;
  logic [8:0]  text_rows;
  logic [15:0] line_pitch;
  logic [31:0] frame_base;
  logic [4:0]  red_shift;
  logic [4:0]  green_shift;
  logic [4:0]  blue_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= 10'd80;
      text_rows    <= 9'd30;
      line_pitch   <= 16'd2560;
      frame_base   <= 32'd0;
      red_shift    <= 5'd16;
      green_shift  <= 5'd8;
      blue_shift   <= 5'd0;
    end else if (cfg_valid) begin
      unique case (cfg_item.index)
        tcgr_pkg::REG_TEXT_COLUMNS: text_columns <= cfg_item.data[9:0];
        tcgr_pkg::REG_TEXT_ROWS:    text_rows    <= cfg_item.data[8:0];
        tcgr_pkg::REG_LINE_PITCH:   line_pitch   <= cfg_item.data[15:0];
        tcgr_pkg::REG_FRAME_BASE:   frame_base   <= cfg_item.data;
        tcgr_pkg::REG_RED_SHIFT:    red_shift    <= cfg_item.data[4:0];
        tcgr_pkg::REG_GREEN_SHIFT:  green_shift  <= cfg_item.data[4:0];
        tcgr_pkg::REG_BLUE_SHIFT:   blue_shift   <= cfg_item.data[4:0];
        default: ;
      endcase
    end
  end

  // effective screen size
  logic [9:0] cols_eff;
  logic [8:0] rows_eff;

  always_comb begin
    if (text_columns == 10'd0) begin
      cols_eff = 10'd1;
    end else if (text_columns > 10'(tcgr_pkg::MAX_COLUMNS)) begin
      cols_eff = 10'(tcgr_pkg::MAX_COLUMNS);
    end else begin
      cols_eff = text_columns;
    end
    if (text_rows == 9'd0) begin
      rows_eff = 9'd1;
    end else if (text_rows > 9'(tcgr_pkg::MAX_ROWS)) begin
      rows_eff = 9'(tcgr_pkg::MAX_ROWS);
    end else begin
      rows_eff = text_rows;
    end
  end

  // cursor advance
  logic [8:0] cursor_column;
  logic [7:0] cursor_row;
  logic [8:0] col_upd;
  logic [7:0] row_upd;
  logic       is_newline;
  logic       draw;
  logic       scroll;
  logic [9:0] col_a;
  logic [9:0] col_b;
  logic [8:0] row_a;
  logic [8:0] row_b;
  logic [8:0] rows_top;

  always_comb begin
    is_newline = (cmd_item.char_code == tcgr_pkg::CHAR_NEWLINE);
    draw       = !is_newline && ({1'b0, cursor_column} < cols_eff) &&
                 ({1'b0, cursor_row} < rows_eff);
    if (is_newline) begin
      col_a = 10'd0;
      row_a = {1'b0, cursor_row} + 9'd1;
    end else begin
      col_a = {1'b0, cursor_column} + 10'd1;
      row_a = {1'b0, cursor_row};
    end
    if (col_a >= cols_eff) begin
      col_b = 10'd0;
      row_b = row_a + 9'd1;
    end else begin
      col_b = col_a;
      row_b = row_a;
    end
    scroll   = (row_b >= rows_eff);
    rows_top = rows_eff - 9'd1;
    col_upd  = scroll ? 9'd0 : col_b[8:0];
    row_upd  = scroll ? rows_top[7:0] : row_b[7:0];
  end

  // glyph base index in the font store
  logic [8:0]      code_wide;
  logic [8:0]      glyph;
  logic [FA_W-1:0] glyph_base;

  always_comb begin
    code_wide  = {1'b0, cmd_item.char_code};
    glyph      = (code_wide >= 9'(GLYPH_COUNT)) ? code_wide - 9'(GLYPH_COUNT) : code_wide;
    glyph_base = FA_W'(glyph) * FA_W'(GLYPH_HEIGHT);
  end

  logic take_char;
  logic take_clear;
  logic font_we;

  assign take_char  = ctrl.take && (cmd_item.op == tcgr_pkg::OP_CHAR);
  assign take_clear = ctrl.take && (cmd_item.op == tcgr_pkg::OP_CLEAR);
  assign font_we    = ctrl.take && (cmd_item.op == tcgr_pkg::OP_LOAD) &&
                      ({1'b0, cmd_item.font_slot} < 13'(FONT_DEPTH));

  // cursor and per-glyph state
  logic [RC_W-1:0]   row_cnt;
  logic              row_last;
  logic              scroll_pend;
  logic [8:0]        draw_col;
  logic [LINE_W-1:0] line_start;
  logic [PROD_W-1:0] prod;
  logic [31:0]       row_addr;

  assign row_last = (row_cnt == RC_W'(GLYPH_HEIGHT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
      scroll_pend   <= 1'b0;
      row_cnt       <= '0;
    end else begin
      if (take_char) begin
        cursor_column <= col_upd;
        cursor_row    <= row_upd;
        scroll_pend   <= scroll;
      end else if (take_clear) begin
        cursor_column <= '0;
        cursor_row    <= '0;
      end
      if (ctrl.seed) begin
        row_cnt <= '0;
      end else if (ctrl.emit_row) begin
        row_cnt <= row_last ? '0 : row_cnt + RC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_char) begin
      draw_col   <= cursor_column;
      line_start <= LINE_W'(cursor_row) * LINE_W'(GLYPH_HEIGHT);
    end
    if (ctrl.mult) begin
      prod <= PROD_W'(line_start) * PROD_W'(line_pitch);
    end
    if (ctrl.seed) begin
      row_addr <= frame_base + {18'd0, draw_col, 5'd0} + 32'(prod);
    end else if (ctrl.emit_row) begin
      row_addr <= row_addr + {16'd0, line_pitch};
    end
  end

  // font store, read port follows the next pointer so data is always current
  logic [7:0]      font_mem [FONT_DEPTH];
  logic [FA_W-1:0] font_ptr;
  logic [FA_W-1:0] font_ptr_next;
  logic [7:0]      font_rd;

  always_comb begin
    if (take_char) begin
      font_ptr_next = glyph_base;
    end else if (ctrl.emit_row && !row_last) begin
      font_ptr_next = font_ptr + FA_W'(1);
    end else begin
      font_ptr_next = font_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      font_ptr <= '0;
    end else begin
      font_ptr <= font_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[cmd_item.font_slot[FA_W-1:0]] <= cmd_item.font_bits;
    end
    font_rd <= font_mem[font_ptr_next];
  end

  // result register
  logic emit;

  assign emit = ctrl.emit_row || ctrl.emit_scroll || ctrl.emit_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_row) begin
      res_item.kind        <= tcgr_pkg::KIND_ROW;
      res_item.row_address <= row_addr;
      res_item.row_pattern <= font_rd;
      res_item.pixel_color <= tcgr_pkg::color_word(red_shift, green_shift, blue_shift);
      res_item.last        <= row_last && !scroll_pend;
    end else if (ctrl.emit_scroll || ctrl.emit_clear) begin
      res_item.kind        <= ctrl.emit_scroll ? tcgr_pkg::KIND_SCROLL : tcgr_pkg::KIND_CLEAR;
      res_item.row_address <= '0;
      res_item.row_pattern <= '0;
      res_item.pixel_color <= '0;
      res_item.last        <= 1'b1;
    end
  end

  always_comb begin
    status.draw        = draw;
    status.scroll      = scroll;
    status.scroll_pend = scroll_pend;
    status.row_last    = row_last;
    status.out_free    = !res_valid || res_ready;
  end

  `ASSERT_HOLDS(a_ptr_range, clk, rst, 32'(font_ptr) < FONT_DEPTH, "font pointer beyond the font store")
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, res_valid && !res_ready, !emit, "result overwritten while stalled")
  `ASSERT_NEXT(a_seed_row0, clk, rst, ctrl.seed, row_cnt == '0, "glyph row counter not restarted")

endmodule

### rtl/text_console_glyph_renderer_top.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top
// character console for a 32 bpp framebuffer: font loads, glyph rows,
// scroll and clear commands
// ----------------------------------------------------------------------------
//
//   channel  dir  payload      what one beat is
//   -------  ---  -----------  ------------------------------------------
//   cmd      in   in_item_t    load font byte / write character / clear
//   cfg      in   cfg_write_t  register write, index and 32-bit data
//   res      out  out_item_t   glyph row write, scroll or clear command
//
// a font load, unknown op, newline or off-screen character is taken in
// idle and ends there, but a clear emits a clear command and a scrolling
// character or newline emits a scroll command; a drawn character runs the
// row base multiply, the address sum, then one glyph row per cycle while
// res is not stalled, out of the font store and result register
// rst is synchronous; the font store is not cleared, so glyphs must be
// loaded before use; res stalls hold the sequencer on its current row
//
module text_console_glyph_renderer_top #(
  parameter int GLYPH_COUNT  = 256,
  parameter int GLYPH_HEIGHT = 16
) (
  input logic          clk,
  input logic          rst,
  tcgr_stream_if.sink   cmd,
  tcgr_stream_if.sink   cfg,
  tcgr_stream_if.source res
);

  tcgr_pkg::ctrl_cmd_t  ctrl;
  tcgr_pkg::dp_status_t status;

  // register writes are always taken; the contract keeps them to idle times
  assign cfg.ready = 1'b1;

  // sequencer: one item at a time, takes cmd only from idle
  tcgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_op    (cmd.payload.op),
    .cmd_ready (cmd.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  // cursor logic, font store, address generation and the result register
  tcgr_datapath #(
    .GLYPH_COUNT  (GLYPH_COUNT),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd_item  (cmd.payload),
    .cfg_valid (cfg.valid),
    .cfg_item  (cfg.payload),
    .ctrl      (ctrl),
    .status    (status),
    .res_item  (res.payload),
    .res_valid (res.valid),
    .res_ready (res.ready)
  );

endmodule
